[design/serial_servo_command_decoder_macros.svh]
// Assertion macros used by the serial servo command decoder top level.
`ifndef SERIAL_SERVO_COMMAND_DECODER_MACROS_SVH
`define SERIAL_SERVO_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

[design/ssc_pkg.sv]
// Types, constants and decode functions of the serial servo command decoder.
package ssc_pkg;

	localparam logic [7:0] ASCII_CR    = 8'h0D;
	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_QUERY = 8'h3F;
	localparam logic [7:0] ASCII_ONE   = 8'h31;
	localparam logic [7:0] ASCII_FOUR  = 8'h34;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_COLON = 8'h3A;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_FOUR_D  = 8'h34;
	localparam logic [7:0] ASCII_SEVEN = 8'h37;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// pulse width codes
	localparam logic [1:0] PW_LOW  = 2'd0;
	localparam logic [1:0] PW_MID  = 2'd1;
	localparam logic [1:0] PW_HIGH = 2'd2;

	localparam logic [10:0] PULSE_LOW  = 11'd1100;
	localparam logic [10:0] PULSE_MID  = 11'd1400;
	localparam logic [10:0] PULSE_HIGH = 11'd1700;

	localparam int         NUM_MOVES  = 12;
	localparam logic [3:0] QUERY_LAST = 4'd8;

	localparam logic [7:0] MOVE_LETTERS [NUM_MOVES] = '{
		8'h71, 8'h61, 8'h7A,  // q a z
		8'h77, 8'h73, 8'h78,  // w s x
		8'h65, 8'h64, 8'h63,  // e d c
		8'h72, 8'h66, 8'h76   // r f v
	};

	// one decoded line command
	typedef struct packed {
		logic       is_query;
		logic [1:0] servo;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] servo;
		logic [1:0] code;
	} move_t;

	function automatic move_t move_lookup(input logic [7:0] c);
		move_t m;
		m = '0;
		for (int i = 0; i < NUM_MOVES; i++) begin
			if (c == MOVE_LETTERS[i]) begin
				m.hit   = 1'b1;
				m.servo = 2'(i / 3);
				m.code  = 2'(i % 3);
			end
		end
		return m;
	endfunction

	function automatic logic [10:0] pulse_of(input logic [1:0] code);
		logic [10:0] p;
		case (code)
			PW_LOW:  p = PULSE_LOW;
			PW_MID:  p = PULSE_MID;
			default: p = PULSE_HIGH;
		endcase
		return p;
	endfunction

	// byte n of "N: PPPP\r\n"; widths are 1100, 1400 or 1700
	function automatic logic [7:0] query_byte(input logic [1:0] idx,
			input logic [1:0] code, input logic [3:0] n);
		logic [7:0] b;
		case (n)
			4'd0: b = ASCII_ONE + {6'd0, idx};
			4'd1: b = ASCII_COLON;
			4'd2: b = ASCII_SPACE;
			4'd3: b = ASCII_ONE;
			4'd4: begin
				case (code)
					PW_LOW:  b = ASCII_ONE;
					PW_MID:  b = ASCII_FOUR_D;
					default: b = ASCII_SEVEN;
				endcase
			end
			4'd5: b = ASCII_ZERO;
			4'd6: b = ASCII_ZERO;
			4'd7: b = ASCII_CR;
			default: b = ASCII_LF;
		endcase
		return b;
	endfunction

endpackage

[design/ssc_stream_if.sv]
// Valid/ready channel interfaces for received bytes and for results.
interface ssc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssc_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic [1:0]  servo_number;
	logic [10:0] pulse_us;
	logic        last;

	modport source (output valid, output kind, output tx_byte, output servo_number,
		output pulse_us, output last, input ready);
	modport sink (input valid, input kind, input tx_byte, input servo_number,
		input pulse_us, input last, output ready);
endinterface

[design/ssc_front.sv]
// Line gatherer: holds the first two characters and classifies the line at CR/LF.
module ssc_front (
	input  logic          clk,
	input  logic          arst_n,
	ssc_rx_if.sink        rx,
	input  logic          full,
	output logic          push,
	output ssc_pkg::cmd_t cmd
);

	logic [1:0] held_q;
	logic [7:0] first_q;
	logic [7:0] second_q;

	logic          accept;
	logic          eol;
	logic [7:0]    c1;
	logic [7:0]    digit_off;
	logic          query_ok;
	ssc_pkg::move_t mv;

	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;
	assign eol      = (rx.rx_byte == ssc_pkg::ASCII_CR) || (rx.rx_byte == ssc_pkg::ASCII_LF);

	always_comb begin
		c1        = (held_q >= 2'd2) ? second_q : 8'd0;
		digit_off = c1 - ssc_pkg::ASCII_ONE;
		query_ok  = (first_q == ssc_pkg::ASCII_QUERY) &&
			(c1 >= ssc_pkg::ASCII_ONE) && (c1 <= ssc_pkg::ASCII_FOUR);
		mv        = ssc_pkg::move_lookup(first_q);
		cmd       = '0;
		if (first_q == ssc_pkg::ASCII_QUERY) begin
			cmd.is_query = 1'b1;
			cmd.servo    = digit_off[1:0];
		end else begin
			cmd.servo = mv.servo;
			cmd.code  = mv.code;
		end
		push = accept && eol && (held_q != 2'd0) && (query_ok || mv.hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 2'd0;
			first_q  <= 8'd0;
			second_q <= 8'd0;
		end else if (accept) begin
			if (eol) begin
				held_q   <= 2'd0;
				first_q  <= 8'd0;
				second_q <= 8'd0;
			end else if (held_q == 2'd0) begin
				first_q <= rx.rx_byte;
				held_q  <= 2'd1;
			end else if (held_q == 2'd1) begin
				second_q <= rx.rx_byte;
				held_q   <= 2'd2;
			end
		end
	end

endmodule

[design/ssc_cmd_fifo.sv]
// Short command queue between the line gatherer and the result sequencer.
module ssc_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssc_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output ssc_pkg::cmd_t pop_data,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ssc_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[design/ssc_back.sv]
// Result sequencer: holds servo widths, emits updates and query text beats.
module ssc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  ssc_pkg::cmd_t cmd,
	output logic          pop,
	ssc_res_if.source     res
);

	logic [1:0] pos_q [4];   // width code per servo
	logic       busy_q;      // query text in progress
	logic [1:0] idx_q;
	logic [3:0] beat_q;

	logic        valid_q;
	logic        kind_q;
	logic [7:0]  tx_q;
	logic [1:0]  servo_q;
	logic [10:0] pulse_q;
	logic        last_q;

	logic can_load;

	assign can_load = !valid_q || res.ready;
	assign pop      = can_load && !busy_q && !empty;

	assign res.valid        = valid_q;
	assign res.kind         = kind_q;
	assign res.tx_byte      = tx_q;
	assign res.servo_number = servo_q;
	assign res.pulse_us     = pulse_q;
	assign res.last         = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			busy_q  <= 1'b0;
			beat_q  <= 4'd0;
			for (int i = 0; i < 4; i++)
				pos_q[i] <= ssc_pkg::PW_HIGH;
		end else if (can_load) begin
			if (busy_q) begin
				valid_q <= 1'b1;
				beat_q  <= beat_q + 4'd1;
				if (beat_q == ssc_pkg::QUERY_LAST)
					busy_q <= 1'b0;
			end else if (!empty) begin
				valid_q <= 1'b1;
				if (cmd.is_query) begin
					busy_q <= 1'b1;
					beat_q <= 4'd1;
				end else begin
					pos_q[cmd.servo] <= cmd.code;
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (busy_q) begin
				kind_q  <= ssc_pkg::KIND_TX;
				tx_q    <= ssc_pkg::query_byte(idx_q, pos_q[idx_q], beat_q);
				servo_q <= 2'd0;
				pulse_q <= 11'd0;
				last_q  <= (beat_q == ssc_pkg::QUERY_LAST);
			end else if (!empty) begin
				idx_q <= cmd.servo;
				if (cmd.is_query) begin
					kind_q  <= ssc_pkg::KIND_TX;
					tx_q    <= ssc_pkg::query_byte(cmd.servo, pos_q[cmd.servo], 4'd0);
					servo_q <= 2'd0;
					pulse_q <= 11'd0;
					last_q  <= 1'b0;
				end else begin
					kind_q  <= ssc_pkg::KIND_UPDATE;
					tx_q    <= 8'd0;
					servo_q <= cmd.servo;
					pulse_q <= ssc_pkg::pulse_of(cmd.code);
					last_q  <= 1'b1;
				end
			end
		end
	end

endmodule

[design/serial_servo_command_decoder.sv]
// Top level of the serial servo command decoder.
//
// rx carries one received character per beat; res carries result beats.
// A line ends at CR or LF. "?1".."?4" yields nine text beats "N: PPPP\r\n"
// (kind 0, last on the LF); a move letter yields one update beat (kind 1,
// servo_number and pulse_us set, last high). Other lines yield nothing.
// Throughput: rx takes one byte per cycle while the command queue has room;
// res delivers one beat per cycle while res.ready is high, and the
// sequencer's beat counter steps a query through its nine text beats.
// A taken CR/LF beat writes its command into the queue; the sequencer then
// pops it into the result register, which drives res.valid.
// When res stalls, the result register holds, the sequencer waits, queued
// commands pile up in the CMD_DEPTH-entry queue, and rx.ready drops only
// when the queue is full. Characters inside a line never need the queue.
// Reset clears the line buffer and queue, drops res.valid, and sets every
// servo to 1700 us; no clearing pass is needed.
`include "serial_servo_command_decoder_macros.svh"

module serial_servo_command_decoder #(
	parameter int CMD_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	ssc_rx_if.sink    rx,
	ssc_res_if.source res
);

	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	ssc_pkg::cmd_t push_cmd;
	ssc_pkg::cmd_t pop_cmd;

	// front: line gathering and classification
	ssc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// decoupling queue
	ssc_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.empty     (empty)
	);

	// back: servo state and result beats
	ssc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.cmd    (pop_cmd),
		.pop    (pop),
		.res    (res)
	);

	// an update beat always closes its command
	`SSC_ASSERT_IMP(a_update_last, clk, arst_n, res.valid && res.kind, res.last)
	// the closing text beat is always the LF
	`SSC_ASSERT_IMP(a_text_last_lf, clk, arst_n,
		res.valid && !res.kind && res.last, res.tx_byte == ssc_pkg::ASCII_LF)
	// only the three legal widths are ever reported
	`SSC_ASSERT_IMP(a_pulse_legal, clk, arst_n, res.valid && res.kind,
		res.pulse_us == ssc_pkg::PULSE_LOW || res.pulse_us == ssc_pkg::PULSE_MID ||
		res.pulse_us == ssc_pkg::PULSE_HIGH)
	// a taken non-last text beat is followed by more of the same query
	`SSC_ASSERT_NEXT(a_text_continues, clk, arst_n,
		res.valid && res.ready && !res.kind && !res.last, res.valid && !res.kind)

endmodule
